>>> hdl/rba_pkg.sv
// ----------------------------------------------------------------------------
// rba_pkg: shared types and constants of the refcounted block allocator
// Table geometry, field widths, request and status codes, controller states.
// ----------------------------------------------------------------------------
package rba_pkg;

  // table and memory geometry
  localparam int unsigned MAX_BLOCKS   = 256;
  localparam int unsigned MEM_BYTES    = 65536;
  localparam int unsigned HEADER_BYTES = 16;

  // field widths
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned SIZE_W   = 17;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned BUMP_W   = 17;
  localparam int unsigned REFS_W   = 16;
  localparam int unsigned NEED_W   = 18;

  // stream widths
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 24;
  localparam int unsigned TUSER_W   = 2;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_ADD_REF  = 2'd2,
    OP_DROP_REF = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_SIZE  = 2'd1,
    ST_NO_SPACE   = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REF,
    S_SCAN,
    S_SCAN_TAIL,
    S_FIN,
    S_DONE
  } state_e;

  // one table entry
  typedef struct packed {
    logic [ADDR_W-1:0] offset;
    logic [SIZE_W-1:0] size;
    logic [REFS_W-1:0] refs;
  } entry_t;

  // one response
  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    logic [ADDR_W-1:0]   addr;
  } result_t;

endpackage

>>> hdl/refcounted_block_allocator_top.sv
// ----------------------------------------------------------------------------
// refcounted_block_allocator_top: reference counted block allocator
// Bump allocation with best-fit reuse of freed blocks, one block table RAM.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on the s_axis channel: tuser carries the operation
//   (allocate, free, add reference, drop reference), tdata the size and the
//   handle. Each request yields exactly one response on the m_axis channel:
//   tuser carries the status, tdata the handle and the payload address.
//   Requests are handled one at a time. A zero-size, bad-handle or bump
//   allocation answers in the accept cycle, as does a no-space answer on an
//   empty table; free and reference updates do a read-modify-write of the
//   block table RAM. An allocation that cannot be carved at the bump
//   pointer scans the table, one entry read per cycle through the RAM port.
//   The response sits in an output register; while the receiver stalls,
//   one further finished response is held internally and new requests are
//   refused until it has moved to the output register.
//   Reset clears the bump pointer, the block count and the handshake state;
//   table entries are written before they are ever read, so the RAM needs
//   no clearing.
module refcounted_block_allocator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request: [16:0] request_size, [24:17] block_handle, zero filled
  input  logic [rba_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  // request: [1:0] operation
  input  logic [rba_pkg::TUSER_W-1:0]         s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // response: [7:0] result_handle, [23:8] payload_address
  output logic [rba_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // response: [1:0] status
  output logic [rba_pkg::TUSER_W-1:0]         m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready
);

  // block table RAM
  rba_pkg::entry_t mem_q [rba_pkg::MAX_BLOCKS];
  rba_pkg::entry_t rd_data_q;

  logic                          mem_we;
  logic [rba_pkg::HANDLE_W-1:0]  mem_waddr;
  rba_pkg::entry_t               mem_wdata;
  logic                          mem_re;
  logic [rba_pkg::HANDLE_W-1:0]  mem_raddr;

  // control state
  rba_pkg::state_e state_q, state_d;
  logic [rba_pkg::BUMP_W-1:0]   bump_q, bump_d;
  logic [rba_pkg::COUNT_W-1:0]  count_q, count_d;
  logic                         out_vld_q;
  logic                         rd_vld_q, rd_vld_d;
  logic                         found_q, found_d;

  // request and scan payload
  rba_pkg::op_e                 op_q;
  logic [rba_pkg::SIZE_W-1:0]   size_q;
  logic [rba_pkg::HANDLE_W-1:0] handle_q;
  logic [rba_pkg::HANDLE_W-1:0] scan_idx_q, scan_idx_d;
  logic [rba_pkg::HANDLE_W-1:0] rd_idx_q;
  logic [rba_pkg::HANDLE_W-1:0] best_idx_q, best_idx_d;
  logic [rba_pkg::SIZE_W-1:0]   best_size_q, best_size_d;
  logic [rba_pkg::ADDR_W-1:0]   best_off_q, best_off_d;
  rba_pkg::result_t             hold_q, out_q;

  // incoming fields
  rba_pkg::op_e                 in_op;
  logic [rba_pkg::SIZE_W-1:0]   in_size;
  logic [rba_pkg::HANDLE_W-1:0] in_handle;
  logic [rba_pkg::NEED_W-1:0]   need;
  logic                         carve_ok;
  logic                         in_accept;

  // response path
  logic             res_vld;
  rba_pkg::result_t res;
  logic             out_free;
  logic             hit;
  logic [rba_pkg::REFS_W-1:0] new_refs;

  assign in_op     = rba_pkg::op_e'(s_axis_tuser);
  assign in_size   = s_axis_tdata[rba_pkg::SIZE_W-1:0];
  assign in_handle = s_axis_tdata[rba_pkg::SIZE_W +: rba_pkg::HANDLE_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_vld_q || m_axis_tready;

  // bump fit check
  assign need = rba_pkg::NEED_W'(bump_q) + rba_pkg::NEED_W'(rba_pkg::HEADER_BYTES)
              + rba_pkg::NEED_W'(in_size);
  assign carve_ok = (need <= rba_pkg::NEED_W'(rba_pkg::MEM_BYTES))
                 && (count_q < rba_pkg::COUNT_W'(rba_pkg::MAX_BLOCKS));

  // best-fit candidate test on the entry just read
  assign hit = (rd_data_q.refs == '0) && (rd_data_q.size >= size_q)
            && (!found_q || (rd_data_q.size < best_size_q));

  // reference count update
  always_comb begin
    new_refs = rd_data_q.refs;
    case (op_q)
      rba_pkg::OP_FREE:     new_refs = '0;
      rba_pkg::OP_ADD_REF:  if (rd_data_q.refs != '1) new_refs = rd_data_q.refs + 1'b1;
      rba_pkg::OP_DROP_REF: if (rd_data_q.refs != '0) new_refs = rd_data_q.refs - 1'b1;
      default:              new_refs = rd_data_q.refs;
    endcase
  end

  // next state and control
  always_comb begin
    state_d       = state_q;
    bump_d        = bump_q;
    count_d       = count_q;
    scan_idx_d    = scan_idx_q;
    rd_vld_d      = 1'b0;
    found_d       = found_q;
    best_idx_d    = best_idx_q;
    best_size_d   = best_size_q;
    best_off_d    = best_off_q;
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    res_vld       = 1'b0;
    res           = '{status: rba_pkg::ST_OK, handle: '0, addr: '0};

    case (state_q)
      rba_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (in_op == rba_pkg::OP_ALLOC) begin
            if (in_size == '0) begin
              res_vld    = 1'b1;
              res.status = rba_pkg::ST_ZERO_SIZE;
            end else if (carve_ok) begin
              // carve a new block at the bump pointer
              mem_we           = 1'b1;
              mem_waddr        = count_q[rba_pkg::HANDLE_W-1:0];
              mem_wdata.offset = rba_pkg::ADDR_W'(bump_q + rba_pkg::BUMP_W'(rba_pkg::HEADER_BYTES));
              mem_wdata.size   = in_size;
              mem_wdata.refs   = rba_pkg::REFS_W'(1);
              bump_d           = need[rba_pkg::BUMP_W-1:0];
              count_d          = count_q + 1'b1;
              res_vld          = 1'b1;
              res.handle       = count_q[rba_pkg::HANDLE_W-1:0];
              res.addr         = mem_wdata.offset;
            end else if (count_q == '0) begin
              res_vld    = 1'b1;
              res.status = rba_pkg::ST_NO_SPACE;
            end else begin
              // fall back to a best-fit scan
              found_d    = 1'b0;
              scan_idx_d = '0;
              state_d    = rba_pkg::S_SCAN;
            end
          end else if ({1'b0, in_handle} >= count_q) begin
            res_vld    = 1'b1;
            res.status = rba_pkg::ST_BAD_HANDLE;
            res.handle = in_handle;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = in_handle;
            state_d   = rba_pkg::S_REF;
          end
          if (res_vld) begin
            state_d = out_free ? rba_pkg::S_IDLE : rba_pkg::S_DONE;
          end
        end
      end

      rba_pkg::S_REF: begin
        mem_we         = 1'b1;
        mem_waddr      = handle_q;
        mem_wdata      = rd_data_q;
        mem_wdata.refs = new_refs;
        res_vld        = 1'b1;
        res.handle     = handle_q;
        res.addr       = rd_data_q.offset;
        state_d        = out_free ? rba_pkg::S_IDLE : rba_pkg::S_DONE;
      end

      rba_pkg::S_SCAN, rba_pkg::S_SCAN_TAIL: begin
        // issue the next read while examining the previous one
        if (state_q == rba_pkg::S_SCAN) begin
          mem_re     = 1'b1;
          mem_raddr  = scan_idx_q;
          rd_vld_d   = 1'b1;
          scan_idx_d = scan_idx_q + 1'b1;
          if ({1'b0, scan_idx_q} == count_q - 1'b1) begin
            state_d = rba_pkg::S_SCAN_TAIL;
          end
        end else begin
          state_d = rba_pkg::S_FIN;
        end
        if (rd_vld_q && hit) begin
          found_d     = 1'b1;
          best_idx_d  = rd_idx_q;
          best_size_d = rd_data_q.size;
          best_off_d  = rd_data_q.offset;
        end
      end

      rba_pkg::S_FIN: begin
        res_vld = 1'b1;
        if (found_q) begin
          mem_we           = 1'b1;
          mem_waddr        = best_idx_q;
          mem_wdata.offset = best_off_q;
          mem_wdata.size   = size_q;
          mem_wdata.refs   = rba_pkg::REFS_W'(1);
          res.handle       = best_idx_q;
          res.addr         = best_off_q;
        end else begin
          res.status = rba_pkg::ST_NO_SPACE;
        end
        state_d = out_free ? rba_pkg::S_IDLE : rba_pkg::S_DONE;
      end

      rba_pkg::S_DONE: begin
        res_vld = 1'b1;
        res     = hold_q;
        if (out_free) begin
          state_d = rba_pkg::S_IDLE;
        end
      end

      default: state_d = rba_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rba_pkg::S_IDLE;
      bump_q    <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      bump_q   <= bump_d;
      count_q  <= count_d;
      rd_vld_q <= rd_vld_d;
      found_q  <= found_d;
      if (res_vld && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= in_op;
      size_q   <= in_size;
      handle_q <= in_handle;
    end
    scan_idx_q  <= scan_idx_d;
    rd_idx_q    <= scan_idx_q;
    best_idx_q  <= best_idx_d;
    best_size_q <= best_size_d;
    best_off_q  <= best_off_d;
    if (res_vld && out_free) begin
      out_q <= res;
    end
    if (res_vld && !out_free) begin
      hold_q <= res;
    end
  end

  // table RAM write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // table RAM read port
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // response channel
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {out_q.addr, out_q.handle};

  // checks
  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rba_pkg::S_SCAN) |-> ({1'b0, scan_idx_q} < count_q))
    else $error("scan read beyond block count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rba_pkg::COUNT_W'(rba_pkg::MAX_BLOCKS))
    else $error("block count above table size");

  a_bump_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= rba_pkg::BUMP_W'(rba_pkg::MEM_BYTES))
    else $error("bump pointer beyond memory");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == rba_pkg::S_IDLE || state_q == rba_pkg::S_REF
             || state_q == rba_pkg::S_FIN))
    else $error("table write outside an update step");

  a_tail_has_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rba_pkg::S_SCAN_TAIL) |-> rd_vld_q)
    else $error("last scan entry not examined");

endmodule
